// ----- rtl/bralu_pkg.sv -----
// Shared types and constants for the byte register ALU.
package bralu_pkg;

    localparam int IDX_W   = 4;
    localparam int IMM_W   = 16;
    localparam int WORD_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int WORD_MAX = 127;
    localparam int WORD_MIN = -128;

    localparam logic signed [WORD_W-1:0] EMPTY_MARK = WORD_W'(WORD_MAX + 1);
    localparam logic signed [IMM_W-1:0]  IMM_MAX    = IMM_W'(WORD_MAX);
    localparam logic signed [IMM_W-1:0]  IMM_MIN    = IMM_W'(WORD_MIN);
    localparam logic signed [PROD_W-1:0] PROD_MAX   = PROD_W'(WORD_MAX);
    localparam logic signed [PROD_W-1:0] PROD_MIN   = PROD_W'(WORD_MIN);

    localparam int DIV_STEPS = BYTE_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);
    localparam int Q_DEPTH   = 2;

    typedef enum logic [3:0] {
        OP_READ  = 4'd0,
        OP_WRITE = 4'd1,
        OP_MOVE  = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MULT  = 4'd5,
        OP_DIV   = 4'd6,
        OP_MOD   = 4'd7,
        OP_COMP  = 4'd8,
        OP_JMP   = 4'd9,
        OP_JNE   = 4'd10,
        OP_JG    = 4'd11,
        OP_JGE   = 4'd12,
        OP_JL    = 4'd13,
        OP_JLE   = 4'd14
    } t_op;

    typedef struct packed {
        logic [3:0]              op;
        logic                    s_mem;
        logic [IDX_W-1:0]        s_idx;
        logic                    d_mem;
        logic [IDX_W-1:0]        d_idx;
        logic signed [IMM_W-1:0] imm;
        logic                    s_ok;
        logic                    d_ok;
        logic                    pair_ok;
        logic                    dmem_ok;
        logic                    imm_ok;
    } t_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     taken;
        logic                     err;
        logic                     z;
        logic                     s;
        logic                     ovf;
    } t_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] dividend;
        logic [BYTE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] quo;
        logic [BYTE_W-1:0] rem;
    } t_div_rsp;

endpackage

// ----- rtl/bralu_front.sv -----
// Front end: accepts items and classifies operand kinds and indexes.
module bralu_front #(
    parameter int NUM_REGS      = 4,
    parameter int NUM_MEM_WORDS = 8
) (
    input  logic                              i_valid,
    input  logic [3:0]                        i_op,
    input  logic                              i_src_is_mem,
    input  logic [bralu_pkg::IDX_W-1:0]       i_src_index,
    input  logic                              i_dst_is_mem,
    input  logic [bralu_pkg::IDX_W-1:0]       i_dst_index,
    input  logic signed [bralu_pkg::IMM_W-1:0] i_immediate,
    input  bralu_pkg::t_q_stat                i_q_stat,
    output logic                              o_stall,
    output logic                              o_push,
    output bralu_pkg::t_item                  o_item
);

    localparam logic [bralu_pkg::IDX_W:0] REG_LIM = NUM_REGS[bralu_pkg::IDX_W:0];
    localparam logic [bralu_pkg::IDX_W:0] MEM_LIM = NUM_MEM_WORDS[bralu_pkg::IDX_W:0];

    logic s_ok, d_ok;

    assign s_ok = i_src_is_mem ? ({1'b0, i_src_index} < MEM_LIM)
                               : ({1'b0, i_src_index} < REG_LIM);
    assign d_ok = i_dst_is_mem ? ({1'b0, i_dst_index} < MEM_LIM)
                               : ({1'b0, i_dst_index} < REG_LIM);

    always_comb begin
        o_item.op      = i_op;
        o_item.s_mem   = i_src_is_mem;
        o_item.s_idx   = i_src_index;
        o_item.d_mem   = i_dst_is_mem;
        o_item.d_idx   = i_dst_index;
        o_item.imm     = i_immediate;
        o_item.s_ok    = s_ok;
        o_item.d_ok    = d_ok;
        o_item.pair_ok = !(i_src_is_mem && i_dst_is_mem) && s_ok && d_ok;
        o_item.dmem_ok = i_dst_is_mem && d_ok;
        o_item.imm_ok  = (i_immediate <= bralu_pkg::IMM_MAX) &&
                         (i_immediate >= bralu_pkg::IMM_MIN);
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

endmodule

// ----- rtl/bralu_queue.sv -----
// Short item queue between front end and execution back end.
module bralu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bralu_pkg::t_item   i_item,
    input  logic               i_pop,
    output bralu_pkg::t_item   o_head,
    output bralu_pkg::t_q_stat o_stat
);

    localparam int DEPTH = bralu_pkg::Q_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    bralu_pkg::t_item r_buf [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_buf[r_rp];
    assign o_stat.full  = (r_cnt == FULL);
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ----- rtl/bralu_div.sv -----
// Restoring divider for 8-bit magnitudes, one quotient bit per cycle.
module bralu_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bralu_pkg::t_div_req i_req,
    output bralu_pkg::t_div_rsp o_rsp
);

    localparam int BW = bralu_pkg::BYTE_W;
    localparam int CW = bralu_pkg::DIV_CW;
    localparam logic [CW-1:0] STEPS = CW'(bralu_pkg::DIV_STEPS);

    logic [BW-1:0] r_rem, r_quo, r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [BW:0]   trial, diff;
    logic          fits;

    assign trial = {r_rem, r_quo[BW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? diff[BW-1:0] : trial[BW-1:0];
                r_quo <= {r_quo[BW-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- rtl/bralu_back.sv -----
// Back end: operand fetch, execution, register file, memory words and flags.
module bralu_back #(
    parameter int NUM_REGS      = 4,
    parameter int NUM_MEM_WORDS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bralu_pkg::t_q_stat  i_q_stat,
    input  bralu_pkg::t_item    i_head,
    output logic                o_pop,
    output bralu_pkg::t_div_req o_div_req,
    input  bralu_pkg::t_div_rsp i_div_rsp,
    input  logic                i_stall,
    output logic                o_valid,
    output bralu_pkg::t_res     o_res
);

    localparam int WW  = bralu_pkg::WORD_W;
    localparam int PW  = bralu_pkg::PROD_W;
    localparam int BW  = bralu_pkg::BYTE_W;
    localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MIW = (NUM_MEM_WORDS > 1) ? $clog2(NUM_MEM_WORDS) : 1;
    localparam logic signed [WW-1:0] EMPTY = bralu_pkg::EMPTY_MARK;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_FIN} t_state;

    t_state                  r_state, n_state;
    bralu_pkg::t_item        r_item;
    logic signed [WW-1:0]    r_rf [NUM_REGS];
    logic [NUM_REGS-1:0]     r_rf_vld;
    logic signed [WW-1:0]    r_mem [NUM_MEM_WORDS];
    logic [NUM_MEM_WORDS-1:0] r_mem_vld;
    logic signed [WW-1:0]    r_reg0;
    logic signed [WW-1:0]    r_vs, r_vd;
    logic                    r_z, r_s, r_ovf;
    logic                    r_o_valid;
    bralu_pkg::t_res         r_res;

    logic                    out_free, commit, div_ok, div_go, is_div;
    logic signed [PW-1:0]    ext_s, ext_d, sum, diff, prod, rng;
    logic                    do_rng;
    logic signed [WW-1:0]    q9, rm9, dres;
    logic signed [WW-1:0]    c_reg0, c_wdata;
    logic                    c_z, c_s, c_ovf, c_err, c_taken, c_wen, c_wmem;
    logic [WW-1:0]           mag_s, mag_d;

    function automatic logic in_byte(input logic signed [PW-1:0] v);
        return (v <= bralu_pkg::PROD_MAX) && (v >= bralu_pkg::PROD_MIN);
    endfunction

    assign ext_s = {{(PW-WW){r_vs[WW-1]}}, r_vs};
    assign ext_d = {{(PW-WW){r_vd[WW-1]}}, r_vd};
    assign sum   = ext_d + ext_s;
    assign diff  = ext_d - ext_s;
    assign prod  = ext_s * ext_d;

    assign is_div = (r_item.op == bralu_pkg::OP_DIV) || (r_item.op == bralu_pkg::OP_MOD);
    assign div_ok = r_item.pair_ok && (r_vs != EMPTY) && (r_vd != EMPTY) && (r_vd != '0);
    assign div_go = is_div && div_ok;

    // signed results from the unsigned divider
    assign mag_s = r_vs[WW-1] ? -r_vs : r_vs;
    assign mag_d = r_vd[WW-1] ? -r_vd : r_vd;
    assign q9    = (r_vs[WW-1] ^ r_vd[WW-1]) ? -$signed({1'b0, i_div_rsp.quo})
                                             : $signed({1'b0, i_div_rsp.quo});
    assign rm9   = r_vs[WW-1] ? -$signed({1'b0, i_div_rsp.rem})
                              : $signed({1'b0, i_div_rsp.rem});
    assign dres  = (r_item.op == bralu_pkg::OP_DIV) ? q9 : rm9;

    assign o_div_req.start    = (r_state == S_EXEC) && div_go;
    assign o_div_req.dividend = mag_s[BW-1:0];
    assign o_div_req.divisor  = mag_d[BW-1:0];

    assign out_free = !r_o_valid || !i_stall;
    assign commit   = out_free && (((r_state == S_EXEC) && !div_go) || (r_state == S_FIN));
    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;

    always_comb begin
        c_reg0  = r_reg0;
        c_z     = r_z;
        c_s     = r_s;
        c_ovf   = r_ovf;
        c_err   = 1'b0;
        c_taken = 1'b0;
        c_wen   = 1'b0;
        c_wmem  = r_item.d_mem;
        c_wdata = r_vs;
        do_rng  = 1'b0;
        rng     = sum;
        case (r_item.op)
            bralu_pkg::OP_READ: begin
                if (!r_item.imm_ok) begin
                    c_ovf = 1'b1;
                end else begin
                    c_ovf   = 1'b0;
                    c_wdata = r_item.imm[WW-1:0];
                    c_wen   = r_item.dmem_ok;
                    c_err   = !r_item.dmem_ok;
                end
            end
            bralu_pkg::OP_WRITE: begin
            end
            bralu_pkg::OP_MOVE: begin
                if (!r_item.pair_ok) begin
                    c_err = 1'b1;
                end else begin
                    c_wen = 1'b1;
                    if (!r_item.d_mem && (r_item.d_idx == '0)) begin
                        c_reg0 = r_vs;
                    end
                end
            end
            bralu_pkg::OP_ADD: begin
                if (!r_item.pair_ok) begin
                    c_err = 1'b1;
                end else begin
                    do_rng = 1'b1;
                end
            end
            bralu_pkg::OP_SUB: begin
                if (!r_item.pair_ok || (r_vs == EMPTY) || (r_vd == EMPTY)) begin
                    c_err  = 1'b1;
                    c_reg0 = EMPTY;
                end else begin
                    do_rng = 1'b1;
                    rng    = diff;
                end
            end
            bralu_pkg::OP_MULT: begin
                if (!r_item.pair_ok) begin
                    c_err  = 1'b1;
                    c_reg0 = EMPTY;
                end else begin
                    do_rng = 1'b1;
                    rng    = prod;
                end
            end
            bralu_pkg::OP_DIV, bralu_pkg::OP_MOD: begin
                c_ovf = 1'b0;
                if (!div_ok) begin
                    c_err  = 1'b1;
                    c_reg0 = EMPTY;
                end else begin
                    c_reg0 = dres;
                    c_s    = dres[WW-1];
                    c_z    = (dres == '0);
                end
            end
            bralu_pkg::OP_COMP: begin
                if (!r_item.pair_ok) begin
                    c_err = 1'b1;
                end else begin
                    c_s = r_vs > r_vd;
                    c_z = r_vs == r_vd;
                end
            end
            bralu_pkg::OP_JMP: c_taken = 1'b1;
            bralu_pkg::OP_JNE: c_taken = !r_z;
            bralu_pkg::OP_JG:  c_taken = !r_z && !r_s;
            bralu_pkg::OP_JGE: c_taken = !r_s;
            bralu_pkg::OP_JL:  c_taken = !r_z && r_s;
            bralu_pkg::OP_JLE: c_taken = r_s;
            default:           c_err   = 1'b1;
        endcase
        if (do_rng) begin
            if (!in_byte(rng)) begin
                c_ovf  = 1'b1;
                c_reg0 = EMPTY;
            end else begin
                c_ovf  = 1'b0;
                c_s    = rng[PW-1];
                c_z    = (rng == '0);
                c_reg0 = rng[WW-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_q_stat.empty) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC: begin
                if (div_go) begin
                    n_state = S_DIV;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV:   if (i_div_rsp.done) n_state = S_FIN;
            S_FIN:   if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_z       <= 1'b0;
            r_s       <= 1'b0;
            r_ovf     <= 1'b0;
            r_reg0    <= EMPTY;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_item <= i_head;
            end
            if (commit) begin
                r_o_valid   <= 1'b1;
                r_z         <= c_z;
                r_s         <= c_s;
                r_ovf       <= c_ovf;
                r_reg0      <= c_reg0;
                r_res.value <= (r_item.op == bralu_pkg::OP_WRITE) ? r_vs : c_reg0;
                r_res.taken <= c_taken;
                r_res.err   <= c_err;
                r_res.z     <= c_z;
                r_res.s     <= c_s;
                r_res.ovf   <= c_ovf;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // storage write port
    always_ff @(posedge i_clk) begin
        if (commit && c_wen) begin
            if (c_wmem) begin
                r_mem[r_item.d_idx[MIW-1:0]] <= c_wdata;
            end else begin
                r_rf[r_item.d_idx[RIW-1:0]] <= c_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_mem_vld <= '0;
        end else if (commit && c_wen) begin
            if (c_wmem) begin
                r_mem_vld[r_item.d_idx[MIW-1:0]] <= 1'b1;
            end else begin
                r_rf_vld[r_item.d_idx[RIW-1:0]] <= 1'b1;
            end
        end
    end

    // operand read ports, source and destination; register 0 comes from its own copy
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            if (!r_item.s_ok) begin
                r_vs <= EMPTY;
            end else if (r_item.s_mem) begin
                r_vs <= r_mem_vld[r_item.s_idx[MIW-1:0]] ? r_mem[r_item.s_idx[MIW-1:0]]
                                                          : EMPTY;
            end else if (r_item.s_idx == '0) begin
                r_vs <= r_reg0;
            end else begin
                r_vs <= r_rf_vld[r_item.s_idx[RIW-1:0]] ? r_rf[r_item.s_idx[RIW-1:0]]
                                                         : EMPTY;
            end
            if (!r_item.d_ok) begin
                r_vd <= EMPTY;
            end else if (r_item.d_mem) begin
                r_vd <= r_mem_vld[r_item.d_idx[MIW-1:0]] ? r_mem[r_item.d_idx[MIW-1:0]]
                                                          : EMPTY;
            end else if (r_item.d_idx == '0) begin
                r_vd <= r_reg0;
            end else begin
                r_vd <= r_rf_vld[r_item.d_idx[RIW-1:0]] ? r_rf[r_item.d_idx[RIW-1:0]]
                                                         : EMPTY;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/byte_register_alu_with_flags_top.sv -----
// Top level of the byte register ALU: front end, item queue, back end and divider.
//
// Executes one decoded instruction per item on a register file and a set of memory
// words, each holding -128..127 or the empty mark 128, with zero, sign and overflow
// flags. Every item gives exactly one result. A two-item queue sits behind the input,
// so items are taken while the back end works or a result waits in the output
// register. The back end handles one item at a time, from the queue head through pop,
// operand read and execute for every op; div and mod also start the shared restoring
// divider, which produces one quotient bit per cycle, wait for it and then finish.
// A result waiting on a stalled output holds the back end. Register and memory
// contents reset to empty at once via valid bits.
module byte_register_alu_with_flags_top #(
    parameter int NUM_REGS      = 4,
    parameter int NUM_MEM_WORDS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [3:0]                         i_op,
    input  logic                               i_src_is_mem,
    input  logic [bralu_pkg::IDX_W-1:0]        i_src_index,
    input  logic                               i_dst_is_mem,
    input  logic [bralu_pkg::IDX_W-1:0]        i_dst_index,
    input  logic signed [bralu_pkg::IMM_W-1:0] i_immediate,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [bralu_pkg::WORD_W-1:0] o_value,
    output logic                               o_branch_taken,
    output logic                               o_error,
    output logic                               o_zero_out,
    output logic                               o_sign_out,
    output logic                               o_overflow_out
);

    bralu_pkg::t_q_stat  q_stat;
    bralu_pkg::t_item    push_item, head_item;
    bralu_pkg::t_div_req div_req;
    bralu_pkg::t_div_rsp div_rsp;
    bralu_pkg::t_res     res;
    logic                push, pop;

    bralu_front #(
        .NUM_REGS      (NUM_REGS),
        .NUM_MEM_WORDS (NUM_MEM_WORDS)
    ) u_front (
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_src_is_mem (i_src_is_mem),
        .i_src_index  (i_src_index),
        .i_dst_is_mem (i_dst_is_mem),
        .i_dst_index  (i_dst_index),
        .i_immediate  (i_immediate),
        .i_q_stat     (q_stat),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_item       (push_item)
    );

    bralu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (q_stat)
    );

    bralu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bralu_back #(
        .NUM_REGS      (NUM_REGS),
        .NUM_MEM_WORDS (NUM_MEM_WORDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (q_stat),
        .i_head    (head_item),
        .o_pop     (pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_res     (res)
    );

    assign o_value        = res.value;
    assign o_branch_taken = res.taken;
    assign o_error        = res.err;
    assign o_zero_out     = res.z;
    assign o_sign_out     = res.s;
    assign o_overflow_out = res.ovf;

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !pop)
        else $error("pop from empty queue");

    a_no_pop_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> !pop)
        else $error("queue popped while a division finishes");

    a_div_multi_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider done one cycle after start");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// ----- test/byte_register_alu_with_flags_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the byte register ALU: directed and random instruction streams.
module byte_register_alu_with_flags_top_tb;

    localparam int NUM_REGS       = 4;
    localparam int NUM_MEM_WORDS  = 8;
    localparam int EMPTY_WORD     = bralu_pkg::WORD_MAX + 1;
    localparam logic [3:0] OP_UNKNOWN = 4'd15;
    localparam int RANDOM_INSTRS  = 1750;
    localparam int DRAIN_AT_INSTR = 1000;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [3:0]                        op;
        logic                              s_mem;
        logic [bralu_pkg::IDX_W-1:0]       s_idx;
        logic                              d_mem;
        logic [bralu_pkg::IDX_W-1:0]       d_idx;
        logic signed [bralu_pkg::IMM_W-1:0] imm;
    } t_instr;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic signed [bralu_pkg::WORD_W-1:0] o_value;
    logic o_branch_taken;
    logic o_error;
    logic o_zero_out;
    logic o_sign_out;
    logic o_overflow_out;

    t_instr drive_instr = '0;

    byte_register_alu_with_flags_top #(
        .NUM_REGS      (NUM_REGS),
        .NUM_MEM_WORDS (NUM_MEM_WORDS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (drive_instr.op),
        .i_src_is_mem   (drive_instr.s_mem),
        .i_src_index    (drive_instr.s_idx),
        .i_dst_is_mem   (drive_instr.d_mem),
        .i_dst_index    (drive_instr.d_idx),
        .i_immediate    (drive_instr.imm),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value        (o_value),
        .o_branch_taken (o_branch_taken),
        .o_error        (o_error),
        .o_zero_out     (o_zero_out),
        .o_sign_out     (o_sign_out),
        .o_overflow_out (o_overflow_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // architectural state of the ALU as the bench sees it
    int reg_words[NUM_REGS];
    int mem_words[NUM_MEM_WORDS];
    bit flag_z, flag_s, flag_v;

    t_instr          pending_instrs[$];
    bralu_pkg::t_res expected_results[$];

    int  instrs_sent = 0;
    int  instrs_accepted = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  error_results = 0;
    int  taken_results = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  tx_burst = 0;
    int  rx_burst = 0;
    int  rx_wait = 0;
    int  rx_draw = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    logic took_instr = 1'b0;
    logic took_result = 1'b0;
    bralu_pkg::t_res got_res, want_res;

    function automatic void clear_state();
        foreach (reg_words[i]) reg_words[i] = EMPTY_WORD;
        foreach (mem_words[i]) mem_words[i] = EMPTY_WORD;
        flag_z = 1'b0;
        flag_s = 1'b0;
        flag_v = 1'b0;
    endfunction

    function automatic bit fetch_word(input logic is_mem,
                                      input logic [bralu_pkg::IDX_W-1:0] idx,
                                      output int v);
        v = 0;
        if (is_mem) begin
            if (idx >= NUM_MEM_WORDS) return 1'b0;
            v = mem_words[idx];
        end else begin
            if (idx >= NUM_REGS) return 1'b0;
            v = reg_words[idx];
        end
        return 1'b1;
    endfunction

    function automatic void track_result(int r);
        flag_s = r < 0;
        flag_z = r == 0;
    endfunction

    // add, sub, mult: out of range empties r0 and sets overflow
    function automatic void commit_arith(int r);
        if (r > bralu_pkg::WORD_MAX || r < bralu_pkg::WORD_MIN) begin
            flag_v = 1'b1;
            reg_words[0] = EMPTY_WORD;
        end else begin
            flag_v = 1'b0;
            track_result(r);
            reg_words[0] = r;
        end
    endfunction

    function automatic bralu_pkg::t_res execute_instr(t_instr c);
        int   vs, vd, q, imm_v, value;
        bit   pair_ok, err, taken;
        bralu_pkg::t_res res;
        vs = 0;
        vd = 0;
        err = 1'b0;
        taken = 1'b0;
        pair_ok = 1'b0;
        imm_v = c.imm;
        if (c.op >= bralu_pkg::OP_MOVE && c.op <= bralu_pkg::OP_COMP)
            pair_ok = !(c.s_mem && c.d_mem) && fetch_word(c.s_mem, c.s_idx, vs) &&
                      fetch_word(c.d_mem, c.d_idx, vd);
        case (c.op)
            bralu_pkg::OP_READ: begin
                if (imm_v > bralu_pkg::WORD_MAX || imm_v < bralu_pkg::WORD_MIN) begin
                    flag_v = 1'b1;
                end else begin
                    flag_v = 1'b0;
                    if (c.d_mem && c.d_idx < NUM_MEM_WORDS) mem_words[c.d_idx] = imm_v;
                    else err = 1'b1;
                end
            end
            bralu_pkg::OP_WRITE: ;
            bralu_pkg::OP_MOVE: begin
                if (!pair_ok) err = 1'b1;
                else if (c.d_mem) mem_words[c.d_idx] = vs;
                else reg_words[c.d_idx] = vs;
            end
            bralu_pkg::OP_ADD: begin
                if (!pair_ok) err = 1'b1;
                else commit_arith(vs + vd);
            end
            bralu_pkg::OP_SUB: begin
                if (!pair_ok || vs == EMPTY_WORD || vd == EMPTY_WORD) begin
                    err = 1'b1;
                    reg_words[0] = EMPTY_WORD;
                end else begin
                    commit_arith(vd - vs);
                end
            end
            bralu_pkg::OP_MULT: begin
                if (!pair_ok) begin
                    err = 1'b1;
                    reg_words[0] = EMPTY_WORD;
                end else begin
                    commit_arith(vs * vd);
                end
            end
            bralu_pkg::OP_DIV, bralu_pkg::OP_MOD: begin
                flag_v = 1'b0;
                if (!pair_ok || vs == EMPTY_WORD || vd == EMPTY_WORD || vd == 0) begin
                    err = 1'b1;
                    reg_words[0] = EMPTY_WORD;
                end else begin
                    q = (c.op == bralu_pkg::OP_DIV) ? vs / vd : vs % vd;
                    track_result(q);
                    reg_words[0] = q;
                end
            end
            bralu_pkg::OP_COMP: begin
                if (!pair_ok) begin
                    err = 1'b1;
                end else begin
                    flag_s = vs > vd;
                    flag_z = vs == vd;
                end
            end
            bralu_pkg::OP_JMP: taken = 1'b1;
            bralu_pkg::OP_JNE: taken = !flag_z;
            bralu_pkg::OP_JG:  taken = !flag_z && !flag_s;
            bralu_pkg::OP_JGE: taken = !flag_s;
            bralu_pkg::OP_JL:  taken = !flag_z && flag_s;
            bralu_pkg::OP_JLE: taken = flag_s;
            default: err = 1'b1;
        endcase
        if (c.op == bralu_pkg::OP_WRITE) begin
            if (!fetch_word(c.s_mem, c.s_idx, value)) value = EMPTY_WORD;
        end else begin
            value = reg_words[0];
        end
        res.value = value[bralu_pkg::WORD_W-1:0];
        res.taken = taken;
        res.err   = err;
        res.z     = flag_z;
        res.s     = flag_s;
        res.ovf   = flag_v;
        return res;
    endfunction

    function automatic t_instr make_instr(logic [3:0] op, logic s_mem,
                                          logic [bralu_pkg::IDX_W-1:0] s_idx, logic d_mem,
                                          logic [bralu_pkg::IDX_W-1:0] d_idx, int imm);
        t_instr c;
        c.op    = op;
        c.s_mem = s_mem;
        c.s_idx = s_idx;
        c.d_mem = d_mem;
        c.d_idx = d_idx;
        c.imm   = imm[bralu_pkg::IMM_W-1:0];
        return c;
    endfunction

    function automatic logic [bralu_pkg::IDX_W-1:0] pick_index(logic is_mem);
        if ($urandom_range(0, 15) == 0) return bralu_pkg::IDX_W'($urandom_range(0, 15));
        return bralu_pkg::IDX_W'(is_mem ? $urandom_range(0, NUM_MEM_WORDS - 1)
                                        : $urandom_range(0, NUM_REGS - 1));
    endfunction

    function automatic t_instr rand_instr();
        t_instr c;
        int     sel, imm_v;
        sel = $urandom_range(0, 99);
        if (sel < 15)      c.op = bralu_pkg::OP_READ;
        else if (sel < 22) c.op = bralu_pkg::OP_WRITE;
        else if (sel < 34) c.op = bralu_pkg::OP_MOVE;
        else if (sel < 45) c.op = bralu_pkg::OP_ADD;
        else if (sel < 55) c.op = bralu_pkg::OP_SUB;
        else if (sel < 63) c.op = bralu_pkg::OP_MULT;
        else if (sel < 71) c.op = bralu_pkg::OP_DIV;
        else if (sel < 78) c.op = bralu_pkg::OP_MOD;
        else if (sel < 86) c.op = bralu_pkg::OP_COMP;
        else if (sel < 99) c.op = 4'($urandom_range(bralu_pkg::OP_JMP, bralu_pkg::OP_JLE));
        else               c.op = OP_UNKNOWN;
        c.s_mem = 1'($urandom_range(0, 1));
        c.d_mem = 1'($urandom_range(0, 1));
        if (c.op == bralu_pkg::OP_READ && $urandom_range(0, 7) != 0) c.d_mem = 1'b1;
        // mostly legal operand pairs, a few memory-to-memory
        if (c.s_mem && c.d_mem && c.op != bralu_pkg::OP_READ && $urandom_range(0, 3) != 0)
            c.s_mem = 1'b0;
        c.s_idx = pick_index(c.s_mem);
        c.d_idx = pick_index(c.d_mem);
        sel = $urandom_range(0, 19);
        if (sel < 3)      imm_v = $urandom_range(0, 65535);
        else if (sel < 8) imm_v = $urandom_range(0, 6) - 3;
        else              imm_v = $urandom_range(0, 255) - 128;
        c.imm = imm_v[bralu_pkg::IMM_W-1:0];
        return c;
    endfunction

    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
    endfunction

    // acceptance of an item updates the bench state in order
    always @(posedge i_clk) begin
        took_instr <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(execute_instr(drive_instr));
            instrs_accepted++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !took_instr) begin
            // stalled: hold the item
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid  <= 1'b0;
        end else if (instrs_sent == DRAIN_AT_INSTR && expected_results.size() != 0) begin
            i_valid <= 1'b0;
        end else if (pending_instrs.size() != 0) begin
            drive_instr <= pending_instrs.pop_front();
            i_valid     <= 1'b1;
            instrs_sent++;
            gap_left    <= draw_wait(tx_burst);
        end else begin
            i_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!held_once && results_seen >= HOLD_AT_RESULT) begin
            held_once <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (took_result) begin
            rx_draw = draw_wait(rx_burst);
            i_stall <= rx_draw != 0;
            rx_wait <= (rx_draw != 0) ? rx_draw - 1 : 0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        took_result <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            got_res = '{o_value, o_branch_taken, o_error, o_zero_out, o_sign_out,
                        o_overflow_out};
            if (o_error) error_results++;
            if (o_branch_taken) taken_results++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none expected: value %0d", $realtime, o_value);
            end else begin
                want_res = expected_results.pop_front();
                if (got_res.value !== want_res.value || got_res.taken !== want_res.taken ||
                    got_res.err !== want_res.err || got_res.z !== want_res.z ||
                    got_res.s !== want_res.s || got_res.ovf !== want_res.ovf) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $write("%0t: result %0d mismatch: exp value %0d br %b err %b ",
                               $realtime, results_seen, want_res.value, want_res.taken,
                               want_res.err);
                        $write("z %b s %b v %b, ", want_res.z, want_res.s, want_res.ovf);
                        $display("got value %0d br %b err %b z %b s %b v %b",
                                 got_res.value, got_res.taken, got_res.err, got_res.z,
                                 got_res.s, got_res.ovf);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        clear_state();
        // extremes of the immediate and bad destinations
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 1, 0, 127));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 1, 1, -128));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 1, 2, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 1, 3, -1));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 1, 15, 1, 4, 32767));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 1, 4, -32768));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 0, 0, 5));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_READ, 0, 0, 1, 15, 5));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_WRITE, 1, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_WRITE, 1, 15, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_MOVE, 1, 0, 0, 1, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_MOVE, 1, 1, 0, 2, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_ADD, 0, 1, 1, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_SUB, 0, 1, 0, 2, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_MULT, 0, 2, 1, 3, 0));
        // -128 / -1 lands on the empty mark
        pending_instrs.push_back(make_instr(bralu_pkg::OP_DIV, 0, 2, 1, 3, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_DIV, 0, 1, 1, 2, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_MOD, 0, 1, 0, 2, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_SUB, 0, 3, 0, 1, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_MOVE, 1, 0, 1, 1, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_COMP, 0, 1, 1, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_JMP, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_JNE, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_JG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_JGE, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_JL, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(bralu_pkg::OP_JLE, 0, 0, 0, 0, 0));
        pending_instrs.push_back(make_instr(OP_UNKNOWN, 1, 15, 1, 15, -1));
        repeat (RANDOM_INSTRS) pending_instrs.push_back(rand_instr());

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_instrs.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d instructions issued, %0d results checked (%0d with error, %0d branches)",
                 instrs_accepted, results_seen, error_results, taken_results);
        $display("included a %0d-cycle output hold-off and a full drain mid-run, %0d cycles",
                 HOLD_CYCLES, cycle_count);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bralu_pkg.sv
rtl/bralu_front.sv
rtl/bralu_queue.sv
rtl/bralu_div.sv
rtl/bralu_back.sv
rtl/byte_register_alu_with_flags_top.sv
test/byte_register_alu_with_flags_top_tb.sv
